// File: sv/csmac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csmac_pkg
// Types and codes shared by the CSMA/CA MAC controller.
// ----------------------------------------------------------------------------
package csmac_pkg;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_FRAME   = 3'd1,
        OP_MEDIUM  = 3'd2,
        OP_RX      = 3'd3,
        OP_TX_DONE = 3'd4
    } opcode_t;

    typedef enum logic [2:0] {
        ACT_NONE     = 3'd0,
        ACT_START_TX = 3'd1,
        ACT_ACK_TX   = 3'd2,
        ACT_DELIVER  = 3'd3,
        ACT_DROP     = 3'd4,
        ACT_GIVE_UP  = 3'd5,
        ACT_TX_OK    = 3'd6,
        ACT_RX_DISC  = 3'd7
    } action_t;

    typedef enum logic [2:0] {
        MS_IDLE    = 3'd0,
        MS_DEFER   = 3'd1,
        MS_DIFS    = 3'd2,
        MS_BACKOFF = 3'd3,
        MS_WTX     = 3'd4,
        MS_WACK    = 3'd5,
        MS_RECV    = 3'd6,
        MS_SIFS    = 3'd7
    } mac_state_t;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_EVENT,
        SQ_DIV,
        SQ_SETTLE,
        SQ_OUT
    } seq_state_t;

    typedef enum logic [2:0] {
        REG_OWN_ADDR = 3'd0,
        REG_USE_ACK  = 3'd1,
        REG_CW_MIN   = 3'd2,
        REG_CW_MAX   = 3'd3,
        REG_RETRY    = 3'd4,
        REG_SLOT     = 3'd5,
        REG_SIFS     = 3'd6,
        REG_DIFS     = 3'd7
    } reg_index_t;

    localparam logic [47:0] BCAST_ADDR = 48'hFFFF_FFFF_FFFF;
    localparam int          DIV_STEPS  = 16;

    typedef struct packed {
        logic [2:0]  opcode;
        logic        medium_free;
        logic        frame_broadcast;
        logic [47:0] rx_receiver_address;
        logic [47:0] rx_transmitter_address;
        logic        rx_is_ack;
        logic        rx_bit_error;
        logic [15:0] random_value;
    } mac_in_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [47:0] ack_address;
        logic [3:0]  retry_count;
        logic [2:0]  mac_state;
        logic [4:0]  queue_count;
    } mac_out_t;

endpackage

// File: sv/csma_ca_mac_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csma_ca_mac_controller
// CSMA/CA medium access control with binary exponential backoff.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carries one event word (tick, new frame, medium
//   change, received frame, transmit done). Every event yields exactly one
//   result word on m_valid/m_ready/m_data.
//   Each accepted word passes through the event, settle and output states;
//   events that draw a backoff slot also pass, between event and settle,
//   the 16 steps of the shared restoring divider that forms random_value mod (window+1).
//   One event is in flight at a time: s_ready is high only when no result
//   is pending, so a new word is accepted only once the last result is taken.
//   A stalled receiver holds the result in the output register and keeps
//   s_ready low until the word is taken.
//   Registers sit on the APB port at 8*index (64-bit data); write only
//   while no event is in flight.
//   Reset (aresetn low, synchronous) returns to idle with an empty queue
//   and restores the register defaults.
// ----------------------------------------------------------------------------
module csma_ca_mac_controller #(
    parameter int QUEUE_DEPTH       = 16,
    parameter int ACK_TIMEOUT_TICKS = 400
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  csmac_pkg::mac_in_t s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output csmac_pkg::mac_out_t m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);
    import csmac_pkg::*;

    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [FW-1:0] FULL_CNT = FW'(QUEUE_DEPTH);
    localparam logic [15:0]   ACK_TO   = 16'(ACK_TIMEOUT_TICKS);

    // configuration
    logic [47:0] own_addr_reg;
    logic        use_ack_reg;
    logic [9:0]  cw_min_reg, cw_max_reg;
    logic [3:0]  retry_limit_reg;
    logic [15:0] slot_ticks_reg, sifs_ticks_reg, difs_ticks_reg;
    logic        cfg_wr;
    reg_index_t  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = reg_index_t'(paddr[5:3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_addr_reg    <= '0;
            use_ack_reg     <= 1'b1;
            cw_min_reg      <= 10'd31;
            cw_max_reg      <= 10'd1023;
            retry_limit_reg <= 4'd7;
            slot_ticks_reg  <= 16'd20;
            sifs_ticks_reg  <= 16'd10;
            difs_ticks_reg  <= 16'd50;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_OWN_ADDR: own_addr_reg    <= pwdata[47:0];
                REG_USE_ACK:  use_ack_reg     <= pwdata[0];
                REG_CW_MIN:   cw_min_reg      <= pwdata[9:0];
                REG_CW_MAX:   cw_max_reg      <= pwdata[9:0];
                REG_RETRY:    retry_limit_reg <= pwdata[3:0];
                REG_SLOT:     slot_ticks_reg  <= pwdata[15:0];
                REG_SIFS:     sifs_ticks_reg  <= pwdata[15:0];
                REG_DIFS:     difs_ticks_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_OWN_ADDR: prdata = {16'd0, own_addr_reg};
            REG_USE_ACK:  prdata = {63'd0, use_ack_reg};
            REG_CW_MIN:   prdata = {54'd0, cw_min_reg};
            REG_CW_MAX:   prdata = {54'd0, cw_max_reg};
            REG_RETRY:    prdata = {60'd0, retry_limit_reg};
            REG_SLOT:     prdata = {48'd0, slot_ticks_reg};
            REG_SIFS:     prdata = {48'd0, sifs_ticks_reg};
            REG_DIFS:     prdata = {48'd0, difs_ticks_reg};
            default:      prdata = '0;
        endcase
    end

    // sequencer
    seq_state_t seq_reg, seq_next;
    mac_in_t    item_reg;
    mac_out_t   out_reg, out_next;
    logic       draw_reg, draw_next;
    logic       enter_bo_reg, enter_bo_next;
    logic [4:0] div_cnt_reg, div_cnt_next;

    // MAC state
    mac_state_t  ms_reg, ms_next;
    logic [15:0] timer_reg, timer_next;
    logic [9:0]  slots_reg, slots_next;
    logic        slot_valid_reg, slot_valid_next;
    logic [15:0] stc_reg, stc_next;
    logic [9:0]  elapsed_reg, elapsed_next;
    logic [3:0]  retry_reg, retry_next;
    logic        needed_reg, needed_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [47:0] ack_addr_reg, ack_addr_next;
    action_t     act_reg, act_next;
    logic        q_reg [QUEUE_DEPTH];
    logic        push, pop;

    // divider
    logic [10:0] rem_reg, rem_next;
    logic [15:0] num_reg, num_next;
    logic [10:0] den_reg, den_next;
    logic [11:0] trial;

    assign s_ready = (seq_reg == SQ_IDLE);
    assign m_valid = (seq_reg == SQ_OUT);
    assign m_data  = out_reg;

    assign trial   = {rem_reg, num_reg[15]};

    always_comb begin
        seq_next = seq_reg;
        case (seq_reg)
            SQ_IDLE:   if (s_valid) seq_next = SQ_EVENT;
            SQ_EVENT:  seq_next = draw_next ? SQ_DIV : SQ_SETTLE;
            SQ_DIV:    if (div_cnt_reg == 5'd1) seq_next = SQ_SETTLE;
            SQ_SETTLE: seq_next = SQ_OUT;
            SQ_OUT:    if (m_ready) seq_next = SQ_IDLE;
            default:   seq_next = SQ_IDLE;
        endcase
    end

    always_comb begin
        logic        expired;
        logic [15:0] tdec;
        logic [FW-1:0] fill_pop;
        logic        fin;
        logic [15:0] stc_inc;
        logic [9:0]  el_inc;
        logic        for_us;
        logic [25:0] cw_wide;
        logic [25:0] cw_m1;
        logic [9:0]  cw;
        ms_next         = ms_reg;
        timer_next      = timer_reg;
        slots_next      = slots_reg;
        slot_valid_next = slot_valid_reg;
        stc_next        = stc_reg;
        elapsed_next    = elapsed_reg;
        retry_next      = retry_reg;
        needed_next     = needed_reg;
        fill_next       = fill_reg;
        ack_addr_next   = ack_addr_reg;
        act_next        = act_reg;
        draw_next       = draw_reg;
        enter_bo_next   = enter_bo_reg;
        div_cnt_next    = div_cnt_reg;
        rem_next        = rem_reg;
        num_next        = num_reg;
        den_next        = den_reg;
        out_next        = out_reg;
        push            = 1'b0;
        pop             = 1'b0;
        expired         = (timer_reg <= 16'd1);
        tdec            = expired ? 16'd0 : timer_reg - 16'd1;
        fill_pop        = (fill_reg == '0) ? fill_reg : fill_reg - FW'(1);
        fin             = 1'b0;
        stc_inc         = stc_reg + 16'd1;
        el_inc          = (elapsed_reg < 10'h3FF) ? elapsed_reg + 10'd1 : elapsed_reg;
        for_us          = (item_reg.rx_receiver_address == own_addr_reg);
        cw_wide         = '0;
        cw_m1           = '0;
        cw              = '0;

        case (seq_reg)
            SQ_EVENT: begin
                act_next      = ACT_NONE;
                draw_next     = 1'b0;
                enter_bo_next = 1'b0;
                case (opcode_t'(item_reg.opcode))
                    OP_TICK: begin
                        case (ms_reg)
                            MS_DIFS: begin
                                timer_next = tdec;
                                if (expired) begin
                                    if (!needed_reg) begin
                                        ms_next  = MS_WTX;
                                        act_next = ACT_START_TX;
                                    end else begin
                                        ms_next      = MS_BACKOFF;
                                        stc_next     = '0;
                                        elapsed_next = '0;
                                        if (!slot_valid_reg) begin
                                            draw_next     = 1'b1;
                                            enter_bo_next = 1'b1;
                                        end else if (slots_reg == '0) begin
                                            ms_next  = MS_WTX;
                                            act_next = ACT_START_TX;
                                        end
                                    end
                                end
                            end
                            MS_BACKOFF: begin
                                stc_next = stc_inc;
                                if (stc_inc >= slot_ticks_reg) begin
                                    stc_next     = '0;
                                    elapsed_next = el_inc;
                                    if (el_inc >= slots_reg) begin
                                        ms_next  = MS_WTX;
                                        act_next = ACT_START_TX;
                                    end
                                end
                            end
                            MS_WACK: begin
                                timer_next = tdec;
                                if (expired) begin
                                    if (5'(retry_reg) + 5'd1 >= 5'(retry_limit_reg)) begin
                                        pop      = 1'b1;
                                        fin      = 1'b1;
                                        ms_next  = MS_IDLE;
                                        act_next = ACT_GIVE_UP;
                                    end else begin
                                        needed_next = 1'b1;
                                        retry_next  = retry_reg + 4'd1;
                                        draw_next   = 1'b1;
                                        ms_next     = MS_DEFER;
                                    end
                                end
                            end
                            MS_SIFS: begin
                                timer_next = tdec;
                                if (expired) begin
                                    act_next        = ACT_ACK_TX;
                                    slots_next      = '0;
                                    slot_valid_next = 1'b1;
                                    retry_next      = '0;
                                    needed_next     = (fill_reg != '0);
                                    ms_next         = MS_IDLE;
                                end
                            end
                            default: ;
                        endcase
                    end
                    OP_FRAME: begin
                        if (fill_reg >= FULL_CNT) begin
                            act_next = ACT_DROP;
                        end else begin
                            push      = 1'b1;
                            fill_next = fill_reg + FW'(1);
                        end
                    end
                    OP_MEDIUM: begin
                        if (ms_reg == MS_DEFER && item_reg.medium_free) begin
                            ms_next    = MS_DIFS;
                            timer_next = difs_ticks_reg;
                        end else if (ms_reg == MS_DIFS && !item_reg.medium_free) begin
                            needed_next = 1'b1;
                            ms_next     = MS_DEFER;
                        end else if (ms_reg == MS_BACKOFF && !item_reg.medium_free) begin
                            slots_next = (elapsed_reg < slots_reg) ? slots_reg - elapsed_reg
                                                                   : 10'd0;
                            ms_next    = MS_DEFER;
                        end
                    end
                    OP_RX: begin
                        if (ms_reg == MS_WACK) begin
                            if (for_us && item_reg.rx_is_ack && !item_reg.rx_bit_error) begin
                                pop      = 1'b1;
                                fin      = 1'b1;
                                ms_next  = MS_IDLE;
                                act_next = ACT_TX_OK;
                            end else begin
                                act_next = ACT_RX_DISC;
                            end
                        end else if (ms_reg != MS_IDLE && ms_reg != MS_DEFER
                                     && ms_reg != MS_DIFS) begin
                            act_next = ACT_RX_DISC;
                        end else if (item_reg.rx_bit_error || item_reg.rx_is_ack
                                     || (item_reg.rx_receiver_address != BCAST_ADDR
                                         && !for_us)) begin
                            act_next        = ACT_RX_DISC;
                            slots_next      = '0;
                            slot_valid_next = 1'b1;
                            retry_next      = '0;
                            needed_next     = (fill_reg != '0);
                            ms_next         = MS_IDLE;
                        end else if (item_reg.rx_receiver_address != BCAST_ADDR
                                     && use_ack_reg) begin
                            act_next      = ACT_DELIVER;
                            ack_addr_next = item_reg.rx_transmitter_address;
                            timer_next    = sifs_ticks_reg;
                            ms_next       = MS_SIFS;
                        end else begin
                            act_next        = ACT_DELIVER;
                            slots_next      = '0;
                            slot_valid_next = 1'b1;
                            retry_next      = '0;
                            needed_next     = (fill_reg != '0);
                            ms_next         = MS_IDLE;
                        end
                    end
                    OP_TX_DONE: begin
                        if (ms_reg == MS_WTX) begin
                            if (q_reg[0] || !use_ack_reg) begin
                                pop      = 1'b1;
                                fin      = 1'b1;
                                ms_next  = MS_IDLE;
                                act_next = ACT_TX_OK;
                            end else begin
                                timer_next = ACK_TO;
                                ms_next    = MS_WACK;
                            end
                        end
                    end
                    default: ;
                endcase
                if (fin) begin
                    fill_next       = fill_pop;
                    slots_next      = '0;
                    slot_valid_next = 1'b1;
                    retry_next      = '0;
                    needed_next     = (fill_pop != '0);
                end
                // window uses the retry count after this event
                cw_wide      = (26'(cw_min_reg) + 26'd1) << retry_next;
                cw_m1        = cw_wide - 26'd1;
                cw           = (cw_m1 > 26'(cw_max_reg)) ? cw_max_reg : cw_m1[9:0];
                rem_next     = '0;
                num_next     = item_reg.random_value;
                den_next     = {1'b0, cw} + 11'd1;
                div_cnt_next = 5'(DIV_STEPS);
            end
            SQ_DIV: begin
                if (trial >= {1'b0, den_reg}) begin
                    rem_next = 11'(trial - {1'b0, den_reg});
                end else begin
                    rem_next = trial[10:0];
                end
                num_next     = {num_reg[14:0], 1'b0};
                div_cnt_next = div_cnt_reg - 5'd1;
                if (div_cnt_reg == 5'd1) begin
                    slots_next      = rem_next[9:0];
                    slot_valid_next = 1'b1;
                    if (enter_bo_reg && rem_next[9:0] == '0) begin
                        ms_next  = MS_WTX;
                        act_next = ACT_START_TX;
                    end
                end
            end
            SQ_SETTLE: begin
                for (int i = 0; i < 4; i++) begin
                    if (ms_next == MS_IDLE && fill_reg != '0) begin
                        slot_valid_next = 1'b0;
                        ms_next         = MS_DEFER;
                    end else if (ms_next == MS_DEFER
                                 && (item_reg.medium_free || !needed_next)) begin
                        ms_next    = MS_DIFS;
                        timer_next = difs_ticks_reg;
                    end else if (ms_next == MS_DIFS && !item_reg.medium_free) begin
                        needed_next = 1'b1;
                        ms_next     = MS_DEFER;
                    end
                end
                out_next.action      = act_reg;
                out_next.ack_address = (act_reg == ACT_ACK_TX) ? ack_addr_reg : 48'd0;
                out_next.retry_count = retry_reg;
                out_next.mac_state   = ms_next;
                out_next.queue_count = 5'(fill_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg        <= SQ_IDLE;
            ms_reg         <= MS_IDLE;
            timer_reg      <= '0;
            slots_reg      <= '0;
            slot_valid_reg <= 1'b0;
            stc_reg        <= '0;
            elapsed_reg    <= '0;
            retry_reg      <= '0;
            needed_reg     <= 1'b0;
            fill_reg       <= '0;
            ack_addr_reg   <= '0;
            act_reg        <= ACT_NONE;
            draw_reg       <= 1'b0;
            enter_bo_reg   <= 1'b0;
            div_cnt_reg    <= '0;
        end else begin
            seq_reg        <= seq_next;
            ms_reg         <= ms_next;
            timer_reg      <= timer_next;
            slots_reg      <= slots_next;
            slot_valid_reg <= slot_valid_next;
            stc_reg        <= stc_next;
            elapsed_reg    <= elapsed_next;
            retry_reg      <= retry_next;
            needed_reg     <= needed_next;
            fill_reg       <= fill_next;
            ack_addr_reg   <= ack_addr_next;
            act_reg        <= act_next;
            draw_reg       <= draw_next;
            enter_bo_reg   <= enter_bo_next;
            div_cnt_reg    <= div_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (seq_reg == SQ_IDLE && s_valid) begin
            item_reg <= s_data;
        end
        rem_reg <= rem_next;
        num_reg <= num_next;
        den_reg <= den_next;
        out_reg <= out_next;
    end

    // transmit queue of broadcast flags, head at entry zero
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[fill_reg[IW-1:0]] <= item_reg.frame_broadcast;
        end else if (pop && fill_reg != '0) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                q_reg[i] <= q_reg[i+1];
            end
        end
    end

    a_ready_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid && seq_reg == SQ_IDLE)
        else $error("ready while busy");

    a_accept_to_event: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> seq_reg == SQ_EVENT)
        else $error("accepted word not processed");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FULL_CNT)
        else $error("queue fill out of range");

    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_reg == SQ_DIV |-> div_cnt_reg != 5'd0 && div_cnt_reg <= 5'(DIV_STEPS))
        else $error("divider count out of range");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(out_reg))
        else $error("result changed while stalled");

endmodule
